[hdl/bdl_pkg.sv]
// Shared types and codes for the bounded double-ended queue.
// Holds the request and response items and the per-cell command.
// No dependencies.
package bdl_pkg;

	localparam int DATA_W = 32;

	// request codes
	localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
	localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [2:0] ACT_POP_BACK   = 3'd3;
	localparam logic [2:0] ACT_LIST       = 3'd4;

	// response codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;
	localparam logic [1:0] STATUS_ELEM  = 2'd3;

	typedef struct packed {
		logic [2:0]               action;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] result_value;
		logic                     last;
	} rsp_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_PUSH_FRONT,
		CELL_PUSH_BACK,
		CELL_POP_FRONT,
		CELL_POP_BACK,
		CELL_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t                 op;
		logic signed [DATA_W-1:0] value;
	} cell_cmd_t;

endpackage

[hdl/bounded_deque_list.sv]
// Bounded double-ended queue of signed 32-bit values, top level.
// Uses bdl_pkg and bdl_chain (a row of bdl_cell).
//
// Usage: drive request (action, value) and raise start; the item is taken at
//   the rising edge where start is high and busy is low. Actions: push front,
//   push back, pop front, pop back, list all. Each result sits on response for
//   one cycle with strobe high and is taken at the edge closing that cycle; the
//   receiver cannot stall, so no result is ever held back.
// Latency and throughput:
//   Push and pop answer in the cycle after the item is taken, and busy stays
//   low, so a new item may follow in the next cycle.
//   List holds busy until it has emitted every stored element, one element
//   per cycle from front to back, the first once the controller has entered
//   its list state; the last one carries last. The single cell-0 read port
//   sets this: the chain rotates one place per cycle and the front cell is
//   read each time, which also restores the order once every element has
//   been read. An empty list answers one empty result in the cycle after the
//   item is taken; unused action codes are dropped without a result.
// Reset: arst_n clears the occupancy bits, the count and the controller;
//   stored values are not cleared and are never read before being written.
module bounded_deque_list #(
	parameter int CAPACITY = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  bdl_pkg::req_t request,
	output logic          busy,
	output logic          strobe,
	output bdl_pkg::rsp_t response
);
	import bdl_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic {
		ST_IDLE,
		ST_LIST
	} state_t;

	state_t                   state_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            remain_q;
	logic                     strobe_q;
	rsp_t                     rsp_q;

	logic                     accept;
	logic                     full;
	logic                     empty;
	cell_cmd_t                cmd;
	logic signed [DATA_W-1:0] head_data;
	logic signed [DATA_W-1:0] tail_data;

	assign busy   = (state_q == ST_LIST);
	assign accept = start && !busy;
	assign full   = (count_q == CW'(CAPACITY));
	assign empty  = (count_q == '0);

	// Steer the chain: rotate while listing, otherwise follow the request.
	always_comb begin
		cmd.op    = CELL_HOLD;
		cmd.value = request.value;
		if (state_q == ST_LIST) begin
			cmd.op = CELL_ROTATE;
		end else if (accept) begin
			case (request.action)
				ACT_PUSH_FRONT: if (!full)  cmd.op = CELL_PUSH_FRONT;
				ACT_PUSH_BACK:  if (!full)  cmd.op = CELL_PUSH_BACK;
				ACT_POP_FRONT:  if (!empty) cmd.op = CELL_POP_FRONT;
				ACT_POP_BACK:   if (!empty) cmd.op = CELL_POP_BACK;
				default:        cmd.op = CELL_HOLD;
			endcase
		end
	end

	bdl_chain #(
		.CELLS (CAPACITY)
	) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.head_data (head_data),
		.tail_data (tail_data)
	);

	// Controller: state, count, list countdown and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			remain_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (state_q == ST_LIST) begin
				// emit the front element and advance the countdown
				strobe_q <= 1'b1;
				remain_q <= remain_q - CW'(1);
				if (remain_q == CW'(1))
					state_q <= ST_IDLE;
			end else if (accept) begin
				case (request.action)
					ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
						strobe_q <= 1'b1;
						if (!full)
							count_q <= count_q + CW'(1);
					end
					ACT_POP_FRONT, ACT_POP_BACK: begin
						strobe_q <= 1'b1;
						if (!empty)
							count_q <= count_q - CW'(1);
					end
					ACT_LIST: begin
						if (empty) begin
							strobe_q <= 1'b1;
						end else begin
							remain_q <= count_q;
							state_q  <= ST_LIST;
						end
					end
					default: strobe_q <= 1'b0;
				endcase
			end
		end
	end

	// Result payload: no reset, qualified by strobe.
	always_ff @(posedge clk) begin
		if (state_q == ST_LIST) begin
			rsp_q.status       <= STATUS_ELEM;
			rsp_q.result_value <= head_data;
			rsp_q.last         <= (remain_q == CW'(1));
		end else if (accept) begin
			rsp_q.result_value <= '0;
			rsp_q.last         <= 1'b1;
			case (request.action)
				ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
					rsp_q.status <= full ? STATUS_FULL : STATUS_OK;
				end
				ACT_POP_FRONT: begin
					rsp_q.status <= empty ? STATUS_EMPTY : STATUS_OK;
					if (!empty)
						rsp_q.result_value <= head_data;
				end
				ACT_POP_BACK: begin
					rsp_q.status <= empty ? STATUS_EMPTY : STATUS_OK;
					if (!empty)
						rsp_q.result_value <= tail_data;
				end
				default: rsp_q.status <= STATUS_EMPTY;
			endcase
		end
	end

	assign strobe   = strobe_q;
	assign response = rsp_q;

endmodule

[hdl/bdl_cell.sv]
// One storage cell of the queue chain: an element and its occupancy bit.
// Uses bdl_pkg for the cell command.
module bdl_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bdl_pkg::cell_cmd_t               cmd,
	input  logic signed [bdl_pkg::DATA_W-1:0] prev_data,
	input  logic                             prev_valid,
	input  logic signed [bdl_pkg::DATA_W-1:0] next_data,
	input  logic                             next_valid,
	input  logic signed [bdl_pkg::DATA_W-1:0] head_data,
	output logic signed [bdl_pkg::DATA_W-1:0] data,
	output logic                             valid
);
	import bdl_pkg::*;

	logic signed [DATA_W-1:0] data_q;
	logic                     valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				CELL_PUSH_FRONT: valid_q <= prev_valid;
				CELL_PUSH_BACK:  if (prev_valid) valid_q <= 1'b1;
				CELL_POP_FRONT:  valid_q <= next_valid;
				CELL_POP_BACK:   if (!next_valid) valid_q <= 1'b0;
				default:         valid_q <= valid_q;
			endcase
		end
	end

	// element data carries no reset
	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_PUSH_FRONT: data_q <= prev_data;
			CELL_PUSH_BACK:  if (!valid_q && prev_valid) data_q <= cmd.value;
			CELL_POP_FRONT:  data_q <= next_data;
			CELL_ROTATE:     if (valid_q) data_q <= next_valid ? next_data : head_data;
			default:         data_q <= data_q;
		endcase
	end

	assign data  = data_q;
	assign valid = valid_q;

endmodule

[hdl/bdl_chain.sv]
// Row of queue cells, front at cell 0, with the head and tail read-out.
// Uses bdl_pkg and bdl_cell.
module bdl_chain #(
	parameter int CELLS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bdl_pkg::cell_cmd_t               cmd,
	output logic signed [bdl_pkg::DATA_W-1:0] head_data,
	output logic signed [bdl_pkg::DATA_W-1:0] tail_data
);
	import bdl_pkg::*;

	logic signed [DATA_W-1:0] data_w  [CELLS];
	logic                     valid_w [CELLS];

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		logic signed [DATA_W-1:0] prev_d, next_d;
		logic                     prev_v, next_v;

		if (i == 0) begin : g_first
			assign prev_d = cmd.value;
			assign prev_v = 1'b1;
		end else begin : g_mid
			assign prev_d = data_w[i-1];
			assign prev_v = valid_w[i-1];
		end

		if (i == CELLS-1) begin : g_end
			assign next_d = '0;
			assign next_v = 1'b0;
		end else begin : g_inner
			assign next_d = data_w[i+1];
			assign next_v = valid_w[i+1];
		end

		bdl_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.prev_data  (prev_d),
			.prev_valid (prev_v),
			.next_data  (next_d),
			.next_valid (next_v),
			.head_data  (data_w[0]),
			.data       (data_w[i]),
			.valid      (valid_w[i])
		);
	end

	assign head_data = data_w[0];

	// the tail is the one occupied cell whose successor is empty
	always_comb begin
		tail_data = '0;
		for (int i = 0; i < CELLS; i++) begin
			if (valid_w[i] && (i == CELLS-1 || !valid_w[(i+1) % CELLS]))
				tail_data = tail_data | data_w[i];
		end
	end

endmodule
